FILE: hw/rtl/assert_macros.svh
// assertion helpers, empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/ort_pkg.sv
`default_nettype none

package ort_pkg;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpRemove = 2'd1,
    OpLookup = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StFull      = 3'd1,
    StProtected = 3'd2,
    StNoEntry   = 3'd3,
    StNoRoute   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_LAST,
    S_REM_SCAN,
    S_LOOK_SCAN
  } state_e;

  typedef struct packed {
    logic [31:0] net;
    logic [31:0] mask;
    logic [31:0] hop;
    logic        direct;
  } route_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ort_ram.sv
`default_nettype none

module ort_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_route_table_core.sv
`default_nettype none
`include "assert_macros.svh"

// Ordered IPv4 route table, one command per start beat while busy is low.
// Entries live in a single-port-read RAM and are walked one entry per
// cycle: a lookup reads from position 0 until the first match, an add walks
// down from the last route shifting entries back until it finds its slot,
// a remove reads its position and then closes up the entries behind it.
// A command that walks the table keeps busy high until it finishes;
// a full-table add, a bad position, an empty-table lookup and an unknown
// op finish without raising busy. The result beat appears on done_o
// for one cycle in the cycle after busy drops and cannot be held off, so
// the receiver must take it then; a new start may be given in that cycle.
module ordered_route_table_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  input  wire logic [1:0]                       op_i,
  input  wire logic [31:0]                      dest_net_i,
  input  wire logic [31:0]                      net_mask_i,
  input  wire logic [31:0]                      hop_addr_i,
  input  wire logic                             is_direct_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]   entry_pos_i,
  input  wire logic [31:0]                      lookup_addr_i,
  output logic                                  busy,
  output logic                                  done_o,
  output logic [2:0]                            status_o,
  output logic [31:0]                           next_hop_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      entry_count_o
);

  localparam int unsigned IdxW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RouteW = $bits(ort_pkg::route_t);

  ort_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic             more_q, more_d;
  logic             rvalid_q;
  logic [IdxW-1:0]  raddr_q;
  ort_pkg::route_t  new_q;
  logic [IdxW-1:0]  pos_q;
  logic [31:0]      addr_q;
  logic             done_q;
  ort_pkg::status_e status_q;
  logic [31:0]      hop_out_q;

  logic             accept;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  ort_pkg::route_t  wr_data;
  logic [RouteW-1:0] rdata_raw;
  ort_pkg::route_t  rdata;
  logic             fin;
  ort_pkg::status_e fin_status;
  logic [31:0]      fin_hop;
  logic             stop;
  logic             match;
  logic             full;
  logic             empty;
  logic [IdxW-1:0]  last_idx;

  assign accept   = start && !busy;
  assign busy     = (state_q != ort_pkg::S_IDLE);
  assign rdata    = ort_pkg::route_t'(rdata_raw);
  assign full     = (count_q == CntW'(TABLE_DEPTH));
  assign empty    = (count_q == '0);
  assign last_idx = IdxW'(count_q - CntW'(1));
  // static route stops the downward walk at a direct entry or a mask not shorter
  assign stop     = !new_q.direct && (rdata.direct || (rdata.mask >= new_q.mask));
  assign match    = ((addr_q & rdata.mask) == rdata.net);

  ort_ram #(
    .Width (RouteW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata_raw)
  );

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = ptr_q;
    wr_en      = 1'b0;
    wr_addr    = raddr_q;
    wr_data    = rdata;
    fin        = 1'b0;
    fin_status = ort_pkg::StOk;
    fin_hop    = '0;
    count_d    = count_q;
    ptr_d      = ptr_q;
    more_d     = more_q;
    case (state_q)
      ort_pkg::S_IDLE: begin
        if (accept) begin
          case (ort_pkg::op_e'(op_i))
            ort_pkg::OpAdd: begin
              if (full) begin
                fin        = 1'b1;
                fin_status = ort_pkg::StFull;
              end else if (!empty) begin
                ptr_d  = last_idx;
                more_d = 1'b1;
              end
            end
            ort_pkg::OpRemove: begin
              if (CntW'(entry_pos_i) >= count_q) begin
                fin        = 1'b1;
                fin_status = ort_pkg::StNoEntry;
              end else begin
                ptr_d  = IdxW'(entry_pos_i);
                more_d = 1'b1;
              end
            end
            ort_pkg::OpLookup: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = ort_pkg::StNoRoute;
              end else begin
                ptr_d  = '0;
                more_d = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ort_pkg::S_ADD_SCAN: begin
        rd_en = more_q;
        if (ptr_q == '0) begin
          more_d = 1'b0;
        end else begin
          ptr_d = ptr_q - IdxW'(1);
        end
        if (rvalid_q) begin
          // every returned entry lands one place back, or the new route does
          wr_en   = 1'b1;
          wr_addr = raddr_q + IdxW'(1);
          if (stop) begin
            wr_data = new_q;
            fin     = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
      end
      ort_pkg::S_ADD_LAST: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_q;
        fin     = 1'b1;
        count_d = count_q + CntW'(1);
      end
      ort_pkg::S_REM_SCAN: begin
        rd_en = more_q;
        if (ptr_q == last_idx) begin
          more_d = 1'b0;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
        if (rvalid_q) begin
          if (raddr_q == pos_q) begin
            if (rdata.direct) begin
              fin        = 1'b1;
              fin_status = ort_pkg::StProtected;
            end else if (raddr_q == last_idx) begin
              fin     = 1'b1;
              count_d = count_q - CntW'(1);
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = raddr_q - IdxW'(1);
            if (raddr_q == last_idx) begin
              fin     = 1'b1;
              count_d = count_q - CntW'(1);
            end
          end
        end
      end
      ort_pkg::S_LOOK_SCAN: begin
        rd_en = more_q;
        if (ptr_q == last_idx) begin
          more_d = 1'b0;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
        if (rvalid_q) begin
          if (match) begin
            fin     = 1'b1;
            fin_hop = rdata.hop;
          end else if (raddr_q == last_idx) begin
            fin        = 1'b1;
            fin_status = ort_pkg::StNoRoute;
          end
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      rd_en  = 1'b0;
      more_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ort_pkg::S_IDLE: begin
        if (accept && !fin) begin
          case (ort_pkg::op_e'(op_i))
            ort_pkg::OpAdd:    state_d = empty ? ort_pkg::S_ADD_LAST : ort_pkg::S_ADD_SCAN;
            ort_pkg::OpRemove: state_d = ort_pkg::S_REM_SCAN;
            ort_pkg::OpLookup: state_d = ort_pkg::S_LOOK_SCAN;
            default:           state_d = ort_pkg::S_IDLE;
          endcase
        end
      end
      ort_pkg::S_ADD_SCAN: begin
        if (fin) begin
          state_d = ort_pkg::S_IDLE;
        end else if (rvalid_q && (raddr_q == '0)) begin
          state_d = ort_pkg::S_ADD_LAST;
        end
      end
      ort_pkg::S_ADD_LAST,
      ort_pkg::S_REM_SCAN,
      ort_pkg::S_LOOK_SCAN: begin
        if (fin) begin
          state_d = ort_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ort_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ort_pkg::S_IDLE;
      count_q  <= '0;
      more_q   <= 1'b0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      more_q   <= more_d;
      rvalid_q <= rd_en;
      done_q   <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    raddr_q <= rd_addr;
    if (accept) begin
      new_q.net    <= dest_net_i;
      new_q.mask   <= net_mask_i;
      new_q.hop    <= is_direct_i ? 32'd0 : hop_addr_i;
      new_q.direct <= is_direct_i;
      pos_q        <= IdxW'(entry_pos_i);
      addr_q       <= lookup_addr_i;
    end
    if (fin) begin
      status_q  <= fin_status;
      hop_out_q <= fin_hop;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign next_hop_o    = hop_out_q;
  assign entry_count_o = count_q;

  `ASSERT_RST(a_done_not_busy, clk_i, rst_ni, (done_o |-> !busy), "result beat while busy")
  `ASSERT_RST(a_count_bound, clk_i, rst_ni, (count_q <= CntW'(TABLE_DEPTH)), "route count above depth")
  `ASSERT_RST(a_full_add, clk_i, rst_ni, ((accept && (op_i == ort_pkg::OpAdd) && full) |=> (done_o && (status_o == ort_pkg::StFull) && $stable(count_q))), "full add not refused")
  `ASSERT_RST(a_wr_range, clk_i, rst_ni, (wr_en |-> (CntW'(wr_addr) <= count_q)), "write beyond table end")

endmodule

`default_nettype wire

FILE: tb/ordered_route_table_core_tb.sv
`default_nettype none

module ordered_route_table_core_tb;

  localparam int unsigned Depth = 16;
  localparam int unsigned NumRandom = 1700;

  typedef struct {
    ort_pkg::op_e op;
    logic [31:0]  net;
    logic [31:0]  mask;
    logic [31:0]  hop;
    logic         direct;
    logic [3:0]   pos;
    logic [31:0]  addr;
  } route_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] hop;
    logic [4:0]  count;
  } route_reply_t;

  // keeps its own copy of the table and the replies still owed by the block
  class route_table_checker;
    ort_pkg::route_t routes[Depth];
    int unsigned     route_count;
    route_reply_t    pending_replies[$];
    int unsigned     mismatches;

    function new();
      route_count = 0;
      mismatches  = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_cmd(route_cmd_t c);
      route_reply_t r;
      int unsigned  pos;
      logic         found;
      r.status = ort_pkg::StOk;
      r.hop    = '0;
      case (c.op)
        ort_pkg::OpAdd: begin
          if (route_count >= Depth) begin
            r.status = ort_pkg::StFull;
          end else begin
            pos = 0;
            // static routes sit behind the direct ones and behind equal or longer masks
            if (!c.direct) begin
              while (pos < route_count && (routes[pos].direct || routes[pos].mask >= c.mask))
                pos++;
            end
            for (int i = route_count; i > pos; i--) routes[i] = routes[i-1];
            routes[pos].net    = c.net;
            routes[pos].mask   = c.mask;
            routes[pos].hop    = c.direct ? 32'h0 : c.hop;
            routes[pos].direct = c.direct;
            route_count++;
          end
        end
        ort_pkg::OpRemove: begin
          if (c.pos >= route_count) begin
            r.status = ort_pkg::StNoEntry;
          end else if (routes[c.pos].direct) begin
            r.status = ort_pkg::StProtected;
          end else begin
            for (int i = c.pos; i + 1 < route_count; i++) routes[i] = routes[i+1];
            route_count--;
          end
        end
        ort_pkg::OpLookup: begin
          found    = 1'b0;
          r.status = ort_pkg::StNoRoute;
          for (int i = 0; i < route_count; i++) begin
            if (!found && (c.addr & routes[i].mask) == routes[i].net) begin
              found    = 1'b1;
              r.status = ort_pkg::StOk;
              r.hop    = routes[i].hop;
            end
          end
        end
        default: ;
      endcase
      r.count = 5'(route_count);
      pending_replies.push_back(r);
    endfunction

    task check_reply(logic [2:0] status, logic [31:0] hop, logic [4:0] count);
      route_reply_t e;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected beat status %0d hop %h count %0d", status, hop, count));
        return;
      end
      e = pending_replies.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, predicted %0d", status, e.status));
      if (hop !== e.hop)
        report($sformatf("next hop %h, predicted %h", hop, e.hop));
      if (count !== e.count)
        report($sformatf("entry count %0d, predicted %0d", count, e.count));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  op_i = '0;
  logic [31:0] dest_net_i = '0;
  logic [31:0] net_mask_i = '0;
  logic [31:0] hop_addr_i = '0;
  logic        is_direct_i = 1'b0;
  logic [3:0]  entry_pos_i = '0;
  logic [31:0] lookup_addr_i = '0;
  logic        busy;
  logic        done_o;
  logic [2:0]  status_o;
  logic [31:0] next_hop_o;
  logic [4:0]  entry_count_o;

  route_table_checker sb = new();

  ordered_route_table_core #(.TABLE_DEPTH(Depth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .op_i          (op_i),
    .dest_net_i    (dest_net_i),
    .net_mask_i    (net_mask_i),
    .hop_addr_i    (hop_addr_i),
    .is_direct_i   (is_direct_i),
    .entry_pos_i   (entry_pos_i),
    .lookup_addr_i (lookup_addr_i),
    .busy          (busy),
    .done_o        (done_o),
    .status_o      (status_o),
    .next_hop_o    (next_hop_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_reply(status_o, next_hop_o, entry_count_o);
  end

  // optional idle gap, then hold the command until a beat is taken
  task automatic issue(input route_cmd_t c, input int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         = 1'b1;
    op_i          = c.op;
    dest_net_i    = c.net;
    net_mask_i    = c.mask;
    hop_addr_i    = c.hop;
    is_direct_i   = c.direct;
    entry_pos_i   = c.pos;
    lookup_addr_i = c.addr;
    do @(posedge clk_i); while (busy);
    sb.note_cmd(c);
  endtask

  task automatic directed(input ort_pkg::op_e op, input logic [31:0] net,
                          input logic [31:0] mask, input logic [31:0] hop,
                          input logic direct, input logic [3:0] pos,
                          input logic [31:0] addr);
    route_cmd_t c;
    c = '{op, net, mask, hop, direct, pos, addr};
    issue(c, 0);
  endtask

  // phase 0 fills the table, phase 1 drains it, anything else is a mix
  function automatic route_cmd_t make_cmd(int unsigned phase);
    route_cmd_t  c;
    int unsigned roll, n_direct, k, len, add_pct, rem_pct;
    logic [31:0] base;
    c.op     = ort_pkg::OpLookup;
    c.net    = $urandom;
    c.mask   = $urandom;
    c.hop    = $urandom;
    c.direct = 1'($urandom);
    c.pos    = 4'($urandom);
    c.addr   = $urandom;
    n_direct = 0;
    for (int i = 0; i < sb.route_count; i++) if (sb.routes[i].direct) n_direct++;
    case (phase)
      0: begin add_pct = 55; rem_pct = 15; end
      1: begin add_pct = 20; rem_pct = 50; end
      default: begin add_pct = 35; rem_pct = 25; end
    endcase
    roll = $urandom_range(99);
    if (roll < 3) begin
      c.op = ort_pkg::OpNone;
    end else if (roll < 3 + add_pct) begin
      c.op = ort_pkg::OpAdd;
      // direct routes can never leave, so only a few are let in
      c.direct = (n_direct < 4) && ($urandom_range(9) == 0);
      len = $urandom_range(32);
      c.mask = (len == 0) ? 32'h0 : 32'hffff_ffff << (32 - len);
      if ($urandom_range(19) == 0) c.mask = $urandom;
      base = $urandom;
      if ($urandom_range(1) == 1) base[31:18] = {8'h0a, 6'h00};
      c.net = base & c.mask;
      if ($urandom_range(9) == 0) c.net = $urandom;
    end else if (roll < 3 + add_pct + rem_pct) begin
      c.op = ort_pkg::OpRemove;
      if (sb.route_count > 0 && $urandom_range(99) < 85)
        c.pos = 4'($urandom_range(sb.route_count - 1));
    end else begin
      c.op = ort_pkg::OpLookup;
      if (sb.route_count > 0 && $urandom_range(99) < 70) begin
        k = $urandom_range(sb.route_count - 1);
        c.addr = (sb.routes[k].net & sb.routes[k].mask) | ($urandom & ~sb.routes[k].mask);
      end else if ($urandom_range(1) == 1) begin
        c.addr[31:18] = {8'h0a, 6'h00};
      end
    end
    return c;
  endfunction

  initial begin
    int unsigned gap;
    int unsigned waited;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, unknown op
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, 4'd0, 32'h0);
    directed(ort_pkg::OpRemove, '0, '0, '0, 1'b0, 4'd0, '0);
    directed(ort_pkg::OpNone, '1, '1, '1, 1'b1, 4'hf, '1);
    // direct route ignores its hop, then nested static prefixes
    directed(ort_pkg::OpAdd, 32'hc0a8_0100, 32'hffff_ff00, 32'hffff_ffff, 1'b1, '0, '0);
    directed(ort_pkg::OpAdd, 32'h0, 32'h0, 32'h0a00_0001, 1'b0, '0, '0);
    directed(ort_pkg::OpAdd, 32'h0a00_0000, 32'hff00_0000, 32'h0000_0001, 1'b0, '0, '0);
    directed(ort_pkg::OpAdd, 32'h0a01_0000, 32'hffff_0000, 32'h0000_0002, 1'b0, '0, '0);
    directed(ort_pkg::OpAdd, 32'h0a01_0200, 32'hffff_ff00, 32'h0000_0003, 1'b0, '0, '0);
    // equal mask lands behind the existing one
    directed(ort_pkg::OpAdd, 32'h0a01_0200, 32'hffff_ff00, 32'h0000_0004, 1'b0, '0, '0);
    directed(ort_pkg::OpAdd, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0005, 1'b0, '0, '0);
    directed(ort_pkg::OpAdd, 32'h0a01_0200, 32'hffff_ff00, 32'h1234_5678, 1'b1, '0, '0);
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, '0, 32'h0a01_0203);
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, '0, 32'h0a01_ff01);
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, '0, 32'hffff_ffff);
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, '0, 32'h0b00_0000);
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, '0, 32'hc0a8_0107);
    directed(ort_pkg::OpRemove, '0, '0, '0, 1'b0, 4'd0, '0);
    directed(ort_pkg::OpRemove, '0, '0, '0, 1'b0, 4'hf, '0);
    directed(ort_pkg::OpRemove, '0, '0, '0, 1'b0, 4'd2, '0);
    directed(ort_pkg::OpRemove, '0, '0, '0, 1'b0, 4'd6, '0);
    directed(ort_pkg::OpLookup, '0, '0, '0, 1'b0, '0, 32'h0b00_0000);

    for (int n = 0; n < NumRandom; n++) begin
      gap = 0;
      // no idling at all in the middle stretch
      if (n < 700 || n >= 1000) begin
        while ($urandom_range(99) < 12) gap++;
      end
      issue(make_cmd((n / 120) % 3), gap);
    end
    @(negedge clk_i);
    start = 1'b0;

    waited = 0;
    while (sb.pending_replies.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (sb.pending_replies.size() != 0)
      sb.report($sformatf("%0d beats never came", sb.pending_replies.size()));

    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
